[design/led_color_phase_sequencer_macros.svh]
// Assertion macros for the LED color phase sequencer.
`ifndef LED_COLOR_PHASE_SEQUENCER_MACROS_SVH
`define LED_COLOR_PHASE_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
`define LCPS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LCPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCPS_ASSERT(lbl, clk, rst, prop, msg)
`define LCPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[design/lcps_pkg.sv]
// Shared types, constants and helpers for the LED color phase sequencer.
package lcps_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int MAX_HOPS    = 4;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int HOPS_W      = $clog2(MAX_HOPS + 1);
   localparam int NUM_LANES   = 3;
   localparam int DIV_STEPS   = 16;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   localparam logic [1:0] SRC_A     = 2'd0;
   localparam logic [1:0] SRC_B     = 2'd1;
   localparam logic [1:0] SRC_C     = 2'd2;
   localparam int         FLAG_DONE_BIT = 7;
   localparam logic [6:0] HOLD_LEN  = 7'd127;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [HOPS_W-1:0] hops_type;

   typedef struct packed {
      logic [1:0]        operation;
      logic [5:0]        phase_addr;
      logic signed [7:0] phase_length;
      logic [7:0]        phase_flags;
      logic [23:0]       color_a;
      logic [23:0]       color_b;
      logic [23:0]       color_c;
   } req_type;

   typedef struct packed {
      logic [23:0] out_color;
      logic        complete;
      logic        jump_error;
   } rsp_type;

   // Start command broadcast to every lane
   typedef struct packed {
      logic       start;
      logic [7:0] step;
      logic [6:0] len;
   } lane_ctl_type;

   // Sequencer state after a finished tick
   typedef struct packed {
      addr_type   phase;
      logic [7:0] step;
   } seq_upd_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_LANES  = 4'b0100,
      ST_FINISH = 4'b1000
   } seq_state_type;

   typedef enum logic [2:0] {
      LN_IDLE = 3'b001,
      LN_PREP = 3'b010,
      LN_DIV  = 3'b100
   } lane_state_type;

   function automatic logic [23:0] pick_color(input logic [1:0] sel,
                                              input logic [23:0] a,
                                              input logic [23:0] b,
                                              input logic [23:0] c);
      logic [23:0] col;
      case (sel)
         SRC_A:   col = a;
         SRC_B:   col = b;
         SRC_C:   col = c;
         default: col = '0;
      endcase
      return col;
   endfunction

endpackage

[design/lcps_lane.sv]
// One color channel lane: multiply, then serial signed divide and add.
`include "led_color_phase_sequencer_macros.svh"
module lcps_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  lcps_pkg::lane_ctl_type ctl,
   input  logic [7:0]            start_chan,
   input  logic [7:0]            end_chan,
   output logic                  done,
   output logic [7:0]            result
);

   lcps_pkg::lane_state_type lst_ff, lst_in;
   logic signed [17:0] prod_ff, prod_in;
   logic [7:0]  s_ff, s_in;
   logic [6:0]  len_ff, len_in;
   logic        neg_ff, neg_in;
   logic [15:0] quo_ff, quo_in;
   logic [6:0]  rem_ff, rem_in;
   logic [lcps_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [7:0]  res_ff, res_in;

   logic signed [8:0] diff;
   logic signed [17:0] prod_neg;
   logic [7:0]  shifted;
   logic        fits;
   logic [15:0] quo_next;
   logic [7:0]  q_low;

   assign diff     = $signed({1'b0, end_chan}) - $signed({1'b0, start_chan});
   assign prod_neg = -prod_ff;
   assign shifted  = {rem_ff, quo_ff[15]};
   assign fits     = shifted >= {1'b0, len_ff};
   assign quo_next = {quo_ff[14:0], fits};
   assign q_low    = neg_ff ? 8'(-quo_next[7:0]) : quo_next[7:0];

   always_comb begin
      lst_in  = lst_ff;
      prod_in = prod_ff;
      s_in    = s_ff;
      len_in  = len_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      case (lst_ff)
         lcps_pkg::LN_IDLE: begin
            if (ctl.start) begin
               prod_in = $signed({1'b0, ctl.step}) * diff;
               s_in    = start_chan;
               len_in  = ctl.len;
               lst_in  = lcps_pkg::LN_PREP;
            end
         end
         lcps_pkg::LN_PREP: begin
            if (len_ff == '0) begin
               // zero length shows the start color, no divide
               res_in  = s_ff;
               done_in = 1'b1;
               lst_in  = lcps_pkg::LN_IDLE;
            end else begin
               neg_in = prod_ff[17];
               quo_in = prod_ff[17] ? prod_neg[15:0] : prod_ff[15:0];
               rem_in = '0;
               cnt_in = '0;
               lst_in = lcps_pkg::LN_DIV;
            end
         end
         lcps_pkg::LN_DIV: begin
            rem_in = fits ? 7'(shifted - {1'b0, len_ff}) : shifted[6:0];
            quo_in = quo_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == lcps_pkg::DIV_CNT_W'(lcps_pkg::DIV_STEPS - 1)) begin
               res_in  = s_ff + q_low;
               done_in = 1'b1;
               lst_in  = lcps_pkg::LN_IDLE;
            end
         end
         default: lst_in = lcps_pkg::LN_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lst_ff  <= lcps_pkg::LN_IDLE;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         lst_ff  <= lst_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      prod_ff <= prod_in;
      s_ff    <= s_in;
      len_ff  <= len_in;
      neg_ff  <= neg_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

   `LCPS_ASSERT(a_lane_start_idle, clock, reset, ctl.start |-> lst_ff == lcps_pkg::LN_IDLE, "lane restarted while busy")
   `LCPS_ASSERT(a_lane_rem_bound, clock, reset, lst_ff == lcps_pkg::LN_DIV |-> rem_ff < len_ff, "divider remainder not below divisor")
   `LCPS_ASSERT(a_lane_done_src, clock, reset, done_ff |-> $past(lst_ff) == lcps_pkg::LN_PREP || $past(lst_ff) == lcps_pkg::LN_DIV, "lane done without a divide")

endmodule

[design/lcps_merge.sv]
// Merges lane bytes into the result and computes the next phase and step.
module lcps_merge (
   input  logic [7:0]                         lane_res [lcps_pkg::NUM_LANES],
   input  logic [7:0]                         flags,
   input  logic [6:0]                         len,
   input  logic [7:0]                         step,
   input  lcps_pkg::addr_type                 idx,
   output lcps_pkg::rsp_type                  rsp,
   output lcps_pkg::seq_upd_type              upd
);

   logic [7:0] step_next;

   always_comb begin
      for (int i = 0; i < lcps_pkg::NUM_LANES; i++) begin
         rsp.out_color[8*i +: 8] = lane_res[i];
      end
      rsp.complete   = flags[lcps_pkg::FLAG_DONE_BIT];
      rsp.jump_error = 1'b0;

      step_next = step + 8'd1;
      if (len != lcps_pkg::HOLD_LEN && step_next >= {1'b0, len}) begin
         upd.step  = '0;
         upd.phase = idx + 1'b1;
      end else begin
         upd.step  = step_next;
         upd.phase = idx;
      end
   end

endmodule

[design/led_color_phase_sequencer.sv]
// Top level: phase table, jump resolution sequencer, three blend lanes.
// Load and start requests go from accept straight to the finish state and result register;
// ticks first follow H backward hops (0..4), with one table read per hop, then run the
// 16-step lane divider, skipped at zero length; a hop error ends the tick without a blend.
// One request in flight at a time; the next is taken once the result is registered.
// Synchronous reset clears phase index, step count and handshake state; table is not cleared.
`include "led_color_phase_sequencer_macros.svh"
module led_color_phase_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lcps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lcps_pkg::rsp_type rsp_data
);

   lcps_pkg::seq_state_type state_ff, state_in;
   lcps_pkg::addr_type phase_ff, phase_in;
   logic [7:0]         step_ff, step_in;
   lcps_pkg::addr_type idx_ff, idx_in;
   lcps_pkg::hops_type hops_ff, hops_in;
   lcps_pkg::req_type  req_ff, req_in;
   logic [6:0]         len_ff, len_in;
   logic [7:0]         flags_ff, flags_in;
   lcps_pkg::rsp_type  res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lcps_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   logic [15:0]        rd_data_ff;
   logic [15:0]        mem [lcps_pkg::TABLE_DEPTH];

   lcps_pkg::addr_type rd_addr;
   logic               accept;
   logic signed [7:0]  ent_len;
   logic [7:0]         ent_flags;
   logic [23:0]        start_col, end_col;
   lcps_pkg::lane_ctl_type lane_ctl;
   logic [lcps_pkg::NUM_LANES-1:0] lane_done;
   logic [7:0]         lane_res [lcps_pkg::NUM_LANES];
   lcps_pkg::rsp_type  merge_rsp;
   lcps_pkg::seq_upd_type merge_upd;
   logic               out_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != lcps_pkg::ST_IDLE;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign ent_len   = $signed(rd_data_ff[15:8]);
   assign ent_flags = rd_data_ff[7:0];
   assign start_col = lcps_pkg::pick_color(ent_flags[5:4], req_ff.color_a,
                                           req_ff.color_b, req_ff.color_c);
   assign end_col   = lcps_pkg::pick_color(ent_flags[1:0], req_ff.color_a,
                                           req_ff.color_b, req_ff.color_c);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      hops_in      = hops_ff;
      req_in       = req_ff;
      len_in       = len_ff;
      flags_in     = flags_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = phase_ff;
      lane_ctl     = '{start: 1'b0, step: step_ff, len: ent_len[6:0]};
      case (state_ff)
         lcps_pkg::ST_IDLE: begin
            if (accept) begin
               req_in  = req_data;
               res_in  = '0;
               idx_in  = phase_ff;
               hops_in = '0;
               if (req_data.operation == lcps_pkg::OP_TICK) begin
                  state_in = lcps_pkg::ST_CHECK;
               end else begin
                  if (req_data.operation == lcps_pkg::OP_START) begin
                     phase_in = lcps_pkg::addr_type'(req_data.phase_addr);
                  end
                  state_in = lcps_pkg::ST_FINISH;
               end
            end
         end
         lcps_pkg::ST_CHECK: begin
            // rd_data_ff holds the entry at idx_ff
            if (ent_len < 0) begin
               if (hops_ff == lcps_pkg::hops_type'(lcps_pkg::MAX_HOPS)) begin
                  res_in.jump_error = 1'b1;
                  state_in = lcps_pkg::ST_FINISH;
               end else begin
                  // backward jump: adding the negative length wraps modulo depth
                  idx_in   = idx_ff + lcps_pkg::addr_type'(ent_len[lcps_pkg::ADDR_W-1:0]);
                  hops_in  = hops_ff + 1'b1;
                  rd_addr  = idx_in;
               end
            end else begin
               lane_ctl.start = 1'b1;
               len_in   = ent_len[6:0];
               flags_in = ent_flags;
               state_in = lcps_pkg::ST_LANES;
            end
         end
         lcps_pkg::ST_LANES: begin
            if (&lane_done) begin
               res_in   = merge_rsp;
               phase_in = merge_upd.phase;
               step_in  = merge_upd.step;
               state_in = lcps_pkg::ST_FINISH;
            end
         end
         lcps_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = lcps_pkg::ST_IDLE;
            end
         end
         default: state_in = lcps_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcps_pkg::ST_IDLE;
         phase_ff     <= '0;
         step_ff      <= '0;
         hops_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         hops_ff      <= hops_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      req_ff      <= req_in;
      len_ff      <= len_in;
      flags_ff    <= flags_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // phase table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (accept && req_data.operation == lcps_pkg::OP_LOAD) begin
         mem[lcps_pkg::addr_type'(req_data.phase_addr)] <=
            {req_data.phase_length, req_data.phase_flags};
      end
      rd_data_ff <= mem[rd_addr];
   end

   for (genvar i = 0; i < lcps_pkg::NUM_LANES; i++) begin : g_lane
      lcps_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctl        (lane_ctl),
         .start_chan (start_col[8*i +: 8]),
         .end_chan   (end_col[8*i +: 8]),
         .done       (lane_done[i]),
         .result     (lane_res[i])
      );
   end

   lcps_merge u_merge (
      .lane_res (lane_res),
      .flags    (flags_ff),
      .len      (len_ff),
      .step     (step_ff),
      .idx      (idx_ff),
      .rsp      (merge_rsp),
      .upd      (merge_upd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `LCPS_ASSERT(a_lanes_in_state, clock, reset, |lane_done |-> state_ff == lcps_pkg::ST_LANES, "lane finished outside blend wait")
   `LCPS_ASSERT(a_hops_bound, clock, reset, state_ff == lcps_pkg::ST_CHECK |-> hops_ff <= lcps_pkg::hops_type'(lcps_pkg::MAX_HOPS), "hop count past bound")
   `LCPS_ASSERT(a_err_clean, clock, reset, rsp_valid_ff && rsp_data_ff.jump_error |-> rsp_data_ff.out_color == '0 && !rsp_data_ff.complete, "jump error with color or complete")
   `LCPS_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid_ff && state_ff == lcps_pkg::ST_IDLE, "reset left control state set")

endmodule

[sim/led_color_phase_sequencer_test.sv]
// Self-checking testbench for the LED color phase sequencer: phase programs scored by a predictor.
module led_color_phase_sequencer_test;
   import lcps_pkg::*;

   localparam logic [1:0] OP_NOP = 2'd3;
   localparam int ITEM_COUNT  = 1950;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int LONG_HOLD   = 500;
   localparam int TAIL_CYCLES = 40;
   localparam int MAX_REPORTS = 10;

   // Predicts the blended color of each request and holds the colors still owed.
   class blend_scoreboard;
      logic [15:0] phase_mem [TABLE_DEPTH];
      bit          mem_written [TABLE_DEPTH];
      addr_type    cur_phase;
      logic [7:0]  step;
      rsp_type     pending_results [$];
      int          mismatches;

      function new();
         cur_phase = '0;
         step = '0;
         mismatches = 0;
         foreach (mem_written[i]) begin
            mem_written[i] = 1'b0;
            phase_mem[i] = '0;
         end
      endfunction

      function int entry_len(addr_type idx);
         logic signed [7:0] l;
         l = phase_mem[idx][15:8];
         return int'(l);
      endfunction

      function logic [23:0] pick_source(logic [1:0] sel, req_type r);
         case (sel)
            SRC_A:   return r.color_a;
            SRC_B:   return r.color_b;
            SRC_C:   return r.color_c;
            default: return 24'h000000;
         endcase
      endfunction

      function logic [7:0] blend_lane(logic [7:0] s, logic [7:0] e, logic [7:0] st, int len);
         int diff;
         int q;
         if (len == 0) return s;
         diff = int'(e) - int'(s);
         q = (int'(st) * diff) / len;
         return 8'(q + int'(s));
      endfunction

      // First table entry a tick would read before it was loaded, or -1.
      function int unwritten_read();
         addr_type idx;
         int len;
         idx = cur_phase;
         for (int hops = 0; hops <= MAX_HOPS; hops++) begin
            if (!mem_written[idx]) return int'(idx);
            len = entry_len(idx);
            if (len >= 0) return -1;
            idx = idx - addr_type'(-len);
         end
         return -1;
      endfunction

      function void note_request(req_type r);
         rsp_type     want;
         addr_type    idx;
         int          len;
         int          hops;
         logic [7:0]  flags;
         logic [23:0] sc;
         logic [23:0] ec;
         bit          bad;
         want = '0;
         case (r.operation)
            OP_LOAD: begin
               phase_mem[r.phase_addr] = {r.phase_length, r.phase_flags};
               mem_written[r.phase_addr] = 1'b1;
            end
            OP_START: cur_phase = r.phase_addr;
            OP_TICK: begin
               idx = cur_phase;
               hops = 0;
               bad = 1'b0;
               len = entry_len(idx);
               while (len < 0 && !bad) begin
                  if (hops >= MAX_HOPS) begin
                     bad = 1'b1;
                  end else begin
                     idx = idx - addr_type'(-len);
                     hops++;
                     len = entry_len(idx);
                  end
               end
               if (bad) begin
                  // chain too long: phase and step stay put
                  want.jump_error = 1'b1;
               end else begin
                  flags = phase_mem[idx][7:0];
                  sc = pick_source(flags[5:4], r);
                  ec = pick_source(flags[1:0], r);
                  for (int ch = 0; ch < 3; ch++)
                     want.out_color[ch*8 +: 8] =
                        blend_lane(sc[ch*8 +: 8], ec[ch*8 +: 8], step, len);
                  want.complete = flags[FLAG_DONE_BIT];
                  cur_phase = idx;
                  step = step + 8'd1;
                  if (len != int'(HOLD_LEN) && int'(step) >= len) begin
                     step = '0;
                     cur_phase = cur_phase + 1'b1;
                  end
               end
            end
            default: ;
         endcase
         pending_results.push_back(want);
      endfunction

      function void report(string what, rsp_type want, rsp_type got);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0s: want color %06h complete %0b error %0b, got color %06h complete %0b error %0b",
                     what, want.out_color, want.complete, want.jump_error,
                     got.out_color, got.complete, got.jump_error);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            report("response with no request", '0, got);
            return;
         end
         want = pending_results.pop_front();
         if (got.out_color !== want.out_color || got.complete !== want.complete ||
             got.jump_error !== want.jump_error)
            report("response mismatch", want, got);
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   bit          hold_go = 1'b0;
   bit          valid_set = 1'b0;
   int          sent = 0;
   int          burst_left = 0;
   int unsigned cycle_count = 0;
   blend_scoreboard sb;

   led_color_phase_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("end of test: mismatches");
      $finish;
   end

   // Receiver: stall pattern changes between random runs, plus one long hold-off.
   initial begin : receiver
      int mode;
      int left;
      int pat;
      mode = 0;
      left = 0;
      pat = 0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 150);
         end
         left--;
         pat++;
         case (mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 2) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (pat % 5 < 2);
         endcase
         @(posedge clock);
      end
   end

   function automatic req_type random_request(logic [1:0] op);
      req_type r;
      r.operation    = op;
      r.phase_addr   = 6'($urandom);
      r.phase_length = 8'($urandom);
      r.phase_flags  = 8'($urandom);
      r.color_a      = 24'($urandom);
      r.color_b      = 24'($urandom);
      r.color_c      = 24'($urandom);
      return r;
   endfunction

   function automatic logic [7:0] program_length(int span);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 8'($urandom_range(0, 6));
      if (roll < 60) return 8'($urandom_range(7, 126));
      if (roll < 65) return 8'(HOLD_LEN);
      if (roll < 82) return 8'(0 - int'($urandom_range(1, span)));
      if (roll < 86) return 8'($urandom_range(128, 255));
      return 8'($urandom_range(1, 3));
   endfunction

   task automatic sender_idle();
      if (valid_set) begin
         req_valid <= 1'b0;
         valid_set = 1'b0;
      end
   endtask

   task automatic send_item(req_type r);
      int gap;
      req_data <= r;
      if (!valid_set) begin
         req_valid <= 1'b1;
         valid_set = 1'b1;
      end
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      if (r.operation != OP_NOP) sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            sender_idle();
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_load(addr_type addr, logic [7:0] len, logic [7:0] flags);
      req_type r;
      r = random_request(OP_LOAD);
      r.phase_addr = addr;
      r.phase_length = len;
      r.phase_flags = flags;
      send_item(r);
   endtask

   task automatic send_start(addr_type addr);
      req_type r;
      r = random_request(OP_START);
      r.phase_addr = addr;
      send_item(r);
   endtask

   // Any entry the tick would read before it was loaded gets loaded first.
   task automatic send_tick(logic [23:0] a, logic [23:0] b, logic [23:0] c);
      req_type r;
      int miss;
      miss = sb.unwritten_read();
      while (miss >= 0) begin
         send_load(addr_type'(miss), 8'($urandom_range(0, 6)), 8'($urandom));
         miss = sb.unwritten_read();
      end
      r = random_request(OP_TICK);
      r.color_a = a;
      r.color_b = b;
      r.color_c = c;
      send_item(r);
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 2))
         0:       send_item(random_request(OP_NOP));
         1:       send_item(random_request(OP_LOAD));
         default: send_item(random_request(OP_START));
      endcase
   endtask

   task automatic drain_results();
      sender_idle();
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin : stimulus
      int n_entries;
      int base;
      int n_ticks;
      int prog;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_item(req_type'({OP_NOP, 6'h3f, 8'hff, 8'hff, 24'hffffff, 24'hffffff, 24'hffffff}));
      send_load(6'd0, 8'h00, 8'h81);   // zero length, complete, A to B
      send_load(6'd1, 8'h03, 8'h12);   // B to C
      send_load(6'd2, 8'h7f, 8'h23);   // hold, C to black
      send_load(6'd3, 8'h80, 8'hff);   // jumps onto itself
      send_tick(24'hffffff, 24'h000000, 24'h123456);
      repeat (3) send_tick(24'hffffff, 24'h000000, 24'h123456);
      repeat (2) send_tick(24'h000000, 24'hffffff, 24'hffffff);
      send_start(6'd3);
      send_tick(24'hffffff, 24'hffffff, 24'hffffff);
      for (int i = 10; i <= 14; i++) send_load(addr_type'(i), 8'hff, 8'h80);
      send_start(6'd14);
      send_tick(24'h00ff00, 24'hff00ff, 24'h0000ff);
      // backward jump across address zero
      send_load(6'd5, 8'hf8, 8'h00);
      send_load(6'd61, 8'h01, 8'hb0);
      send_start(6'd5);
      send_tick(24'($urandom), 24'($urandom), 24'($urandom));
      drain_results();

      // hold phase long enough for the step count to wrap
      base = $urandom_range(0, 63);
      send_load(addr_type'(base), 8'(HOLD_LEN), 8'($urandom));
      send_start(addr_type'(base));
      repeat (270) send_tick(24'($urandom), 24'($urandom), 24'($urandom));

      prog = 0;
      while (sent < ITEM_COUNT) begin
         prog++;
         if (prog == 4) hold_go = 1'b1;
         n_entries = $urandom_range(2, 8);
         base = $urandom_range(0, 63);
         for (int i = 0; i < n_entries; i++)
            send_load(addr_type'(base + i), program_length(i + 1), 8'($urandom));
         if ($urandom_range(0, 3) == 0)
            send_start(addr_type'(base + $urandom_range(0, n_entries - 1)));
         else
            send_start(addr_type'(base));
         n_ticks = $urandom_range(5, 40);
         repeat (n_ticks) send_tick(24'($urandom), 24'($urandom), 24'($urandom));
         if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) send_noise();
         if (prog % 8 == 0) drain_results();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      sb.mismatches += sb.pending();
      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[led_color_phase_sequencer.f]
+incdir+design
design/lcps_pkg.sv
design/lcps_lane.sv
design/lcps_merge.sv
design/led_color_phase_sequencer.sv
sim/led_color_phase_sequencer_test.sv
